// ===== src/spdc_pkg.sv =====
// Shared types and constants for the serial packet deframer.
// Used by the front parser, the command queue, the write-back engine and the top level.
// Depends on nothing.
package spdc_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int CNT_W  = 6;

    localparam logic [BYTE_W-1:0] START_RESET  = 8'h01;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h1B;

    // Result kinds as they appear on the output port.
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_NAK   = 2'd2
    } kind_t;

    // Configuration register indexes.
    typedef enum logic {
        REG_START  = 1'b0,
        REG_ESCAPE = 1'b1
    } reg_index_t;

    // Command passed from the parser to the write-back engine.
    typedef struct packed {
        kind_t               kind;
        logic                done;
        logic [CNT_W-1:0]    len;
        logic [WORD_W-1:0]   base;
    } cmd_t;

    // Write port of the word buffer, driven by the parser.
    typedef struct packed {
        logic                en;
        logic [CNT_W-1:0]    idx;
        logic [WORD_W-1:0]   data;
    } buf_wr_t;

endpackage

// ===== src/spdc_front.sv =====
// Byte parser of the deframer: start hunt, escapes, word assembly and checksum.
// Issues commands into the queue and writes data words into the back end's buffer.
// Depends on spdc_pkg.
module spdc_front #(
    parameter int MAX_WORDS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [spdc_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [spdc_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                         cmd_full,
    input  logic                         lock,
    output logic                         cmd_push,
    output spdc_pkg::cmd_t               cmd_out,
    output spdc_pkg::buf_wr_t            buf_wr
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_BASE = 3'd2,
        PH_DATA = 3'd3,
        PH_SUM  = 3'd4
    } phase_t;

    localparam int CW = spdc_pkg::CNT_W;
    localparam int WW = spdc_pkg::WORD_W;

    phase_t                        phase_reg, phase_next;
    logic                          esc_reg, esc_next;
    logic                          half_reg, half_next;
    logic [spdc_pkg::BYTE_W-1:0]   low_reg, low_next;
    logic [WW-1:0]                 len_reg, len_next;
    logic [WW-1:0]                 base_reg, base_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [WW-1:0]                 sum_reg, sum_next;
    logic                          fin_reg, fin_next;
    logic [spdc_pkg::BYTE_W-1:0]   start_reg, escape_reg;
    logic                          accept;
    logic [WW-1:0]                 word;
    logic [CW-1:0]                 cnt_inc;

    // Data bytes wait while the back end still reads the buffer.
    assign in_ready = !cmd_full && !(phase_reg == PH_DATA && lock);
    assign accept   = in_valid && in_ready;
    assign word     = {rx_byte, low_reg};
    assign cnt_inc  = cnt_reg + CW'(1);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= spdc_pkg::START_RESET;
            escape_reg <= spdc_pkg::ESCAPE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (spdc_pkg::reg_index_t'(cfg_index))
                spdc_pkg::REG_START:  start_reg  <= cfg_data;
                spdc_pkg::REG_ESCAPE: escape_reg <= cfg_data;
                default:              start_reg  <= start_reg;
            endcase
        end
    end

    // Next-state logic for one accepted byte.
    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        half_next  = half_reg;
        low_next   = low_reg;
        len_next   = len_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        fin_next   = fin_reg;
        cmd_push   = 1'b0;
        cmd_out    = '{kind: spdc_pkg::KIND_NAK, done: 1'b0, len: len_reg[CW-1:0],
                       base: base_reg};
        buf_wr     = '{en: 1'b0, idx: cnt_reg, data: word};
        if (accept && !fin_reg)
        begin
            if (phase_reg == PH_HUNT)
            begin
                if (rx_byte == start_reg)
                begin
                    phase_next = PH_LEN;
                    esc_next   = 1'b0;
                    half_next  = 1'b0;
                end
            end
            else if (!esc_reg && rx_byte == escape_reg)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                if (!half_reg)
                begin
                    low_next  = rx_byte;
                    half_next = 1'b1;
                end
                else
                begin
                    half_next = 1'b0;
                    unique case (phase_reg)
                        PH_LEN:
                        begin
                            len_next   = word;
                            sum_next   = word;
                            phase_next = PH_BASE;
                        end
                        PH_BASE:
                        begin
                            base_next = word;
                            sum_next  = sum_reg + word;
                            cnt_next  = '0;
                            if (len_reg > WW'(MAX_WORDS))
                            begin
                                cmd_push   = 1'b1;
                                phase_next = PH_HUNT;
                            end
                            else if (len_reg == '0)
                                phase_next = PH_SUM;
                            else
                                phase_next = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            buf_wr.en = 1'b1;
                            cnt_next  = cnt_inc;
                            sum_next  = sum_reg + word;
                            if (WW'(cnt_inc) >= len_reg)
                                phase_next = PH_SUM;
                        end
                        PH_SUM:
                        begin
                            phase_next = PH_HUNT;
                            cmd_push   = 1'b1;
                            if (word == sum_reg)
                            begin
                                cmd_out.kind = spdc_pkg::KIND_ACK;
                                cmd_out.done = (len_reg == '0);
                                if (len_reg == '0)
                                    fin_next = 1'b1;
                            end
                        end
                        default:
                            phase_next = PH_HUNT;
                    endcase
                end
            end
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            esc_reg   <= 1'b0;
            half_reg  <= 1'b0;
            low_reg   <= '0;
            len_reg   <= '0;
            base_reg  <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            half_reg  <= half_next;
            low_reg   <= low_next;
            len_reg   <= len_next;
            base_reg  <= base_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            fin_reg   <= fin_next;
        end
    end

    // A command is never pushed into a full queue.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into a full queue");

    // The buffer is never written while the back end may be reading it.
    a_buf_lock: assert property (@(posedge clk) disable iff (!rst_n)
        buf_wr.en |-> !lock)
        else $error("buffer written while locked");

    // Once the upload is done, nothing more is queued.
    a_fin_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |=> fin_reg && !cmd_push)
        else $error("activity after upload done");

endmodule

// ===== src/spdc_fifo.sv =====
// Two-entry command queue between the parser and the write-back engine.
// Depends on spdc_pkg.
module spdc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spdc_pkg::cmd_t  push_data,
    input  logic            pop,
    output spdc_pkg::cmd_t  pop_data,
    output logic            full,
    output logic            empty
);

    spdc_pkg::cmd_t  slot_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== src/spdc_back.sv =====
// Write-back engine: turns commands into ack, nak and memory write transactions.
// Holds the word buffer and the output register.
// Depends on spdc_pkg.
module spdc_back #(
    parameter int MAX_WORDS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  spdc_pkg::buf_wr_t            buf_wr,
    input  logic                         cmd_empty,
    input  spdc_pkg::cmd_t               cmd_in,
    output logic                         cmd_pop,
    output logic                         busy,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [spdc_pkg::WORD_W-1:0]  word_address,
    output logic [spdc_pkg::WORD_W-1:0]  word_data,
    output logic                         upload_done,
    output logic                         last
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FETCH = 2'd1,
        S_WRITE = 2'd2
    } state_t;

    localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW    = spdc_pkg::CNT_W;
    localparam int WW    = spdc_pkg::WORD_W;

    logic [WW-1:0]     buf_mem [MAX_WORDS];
    logic [WW-1:0]     rd_data_reg;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [WW-1:0]     base_reg, base_next;
    logic              valid_reg, valid_next;
    spdc_pkg::kind_t   kind_reg, kind_next;
    logic [WW-1:0]     addr_reg, addr_next;
    logic [WW-1:0]     data_reg, data_next;
    logic              done_reg, done_next;
    logic              last_reg, last_next;
    logic              out_free;

    assign out_free     = !valid_reg || out_ready;
    assign busy         = (state_reg != S_IDLE);
    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign word_address = addr_reg;
    assign word_data    = data_reg;
    assign upload_done  = done_reg;
    assign last         = last_reg;

    // Word buffer: one write port from the parser, one registered read port.
    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
            buf_mem[buf_wr.idx[IDX_W-1:0]] <= buf_wr.data;
        rd_data_reg <= buf_mem[cnt_reg[IDX_W-1:0]];
    end

    // Command sequencing and output register loading.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        base_next  = base_reg;
        valid_next = valid_reg && !out_ready;
        kind_next  = kind_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        done_next  = done_reg;
        last_next  = last_reg;
        cmd_pop    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty && out_free)
                begin
                    cmd_pop    = 1'b1;
                    valid_next = 1'b1;
                    kind_next  = cmd_in.kind;
                    addr_next  = '0;
                    data_next  = '0;
                    done_next  = cmd_in.done;
                    base_next  = {1'b0, cmd_in.base[WW-1:1]};
                    len_next   = cmd_in.len;
                    cnt_next   = '0;
                    if (cmd_in.kind == spdc_pkg::KIND_ACK && cmd_in.len != '0)
                    begin
                        last_next  = 1'b0;
                        state_next = S_FETCH;
                    end
                    else
                        last_next = 1'b1;
                end
            end
            S_FETCH:
                state_next = S_WRITE;
            S_WRITE:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    kind_next  = spdc_pkg::KIND_WRITE;
                    addr_next  = base_reg + WW'(cnt_reg);
                    data_next  = rd_data_reg;
                    done_next  = 1'b0;
                    cnt_next   = cnt_reg + CW'(1);
                    if (cnt_next == len_reg)
                    begin
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        last_next  = 1'b0;
                        state_next = S_FETCH;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            len_reg   <= '0;
            base_reg  <= '0;
            kind_reg  <= spdc_pkg::KIND_WRITE;
            addr_reg  <= '0;
            data_reg  <= '0;
            done_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            base_reg  <= base_next;
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            done_reg  <= done_next;
            last_reg  <= last_next;
        end
    end

    // Commands are taken only between drains.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> state_reg == S_IDLE && !cmd_empty)
        else $error("command taken while draining");

    // The drain index stays below the packet length.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> cnt_reg < len_reg)
        else $error("drain index out of range");

    // The upload-done ack is always the final result of its byte.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && done_reg |-> last_reg && kind_reg == spdc_pkg::KIND_ACK)
        else $error("upload done on a wrong result");

endmodule

// ===== src/serial_packet_deframer_checksum.sv =====
// Top level of the serial packet deframer with additive checksum.
// Instantiates spdc_front, spdc_fifo and spdc_back; depends on spdc_pkg.
//
// Usage:
// - Input channel (in_valid/in_ready/rx_byte) takes one received byte per
//   transaction. Bytes are dropped until a raw start byte, then read as escaped
//   little-endian words: length, byte base, data words and checksum.
// - Output channel (out_valid/out_ready) carries ack, nak and memory write
//   transactions; last marks the final result caused by one input byte.
// - Configuration port (cfg_we/cfg_index/cfg_data) sets the start byte
//   (index 0) and the escape byte (index 1); write it only while idle.
// The ack or nak of a byte that ends a packet passes through the command
// queue and then the output register. The write-back engine then emits its
// memory writes one at a time, each fetched through the registered buffer
// read port. Data bytes of the next packet wait until the queue is empty and
// the drain has ended; all other bytes go at one per cycle while the command
// queue is not full.
// Reset clears all control state and restores the default start and escape
// bytes; the word buffer is not cleared. When the receiver stalls, the output
// register holds its transaction, the command queue fills, and in_ready drops.
module serial_packet_deframer_checksum #(
    parameter int MAX_WORDS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [spdc_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [spdc_pkg::BYTE_W-1:0]  rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [spdc_pkg::WORD_W-1:0]  word_address,
    output logic [spdc_pkg::WORD_W-1:0]  word_data,
    output logic                         upload_done,
    output logic                         last
);

    spdc_pkg::cmd_t     push_cmd, pop_cmd;
    spdc_pkg::buf_wr_t  buf_wr;
    logic               cmd_push, cmd_pop, cmd_full, cmd_empty;
    logic               back_busy, lock;

    // The buffer is in use while any command waits or a drain runs.
    assign lock = !cmd_empty || back_busy;

    // Byte parser.
    spdc_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .cmd_full  (cmd_full),
        .lock      (lock),
        .cmd_push  (cmd_push),
        .cmd_out   (push_cmd),
        .buf_wr    (buf_wr)
    );

    // Command queue.
    spdc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_cmd),
        .pop       (cmd_pop),
        .pop_data  (pop_cmd),
        .full      (cmd_full),
        .empty     (cmd_empty)
    );

    // Write-back engine.
    spdc_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .buf_wr       (buf_wr),
        .cmd_empty    (cmd_empty),
        .cmd_in       (pop_cmd),
        .cmd_pop      (cmd_pop),
        .busy         (back_busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .word_address (word_address),
        .word_data    (word_data),
        .upload_done  (upload_done),
        .last         (last)
    );

endmodule
